### sv/tgfc_pkg.sv
// Package: shared types, register map and constants of the thermocouple filter.
`timescale 1ns / 1ps
package tgfc_pkg;

  localparam int unsigned TempW  = 19;            // held / output temperature
  localparam int unsigned TcW    = 19;            // raw thermocouple reading
  localparam int unsigned CjW    = 15;            // cold junction reading
  localparam int unsigned DiffW  = 20;            // tc - cj, and held - tc
  localparam int unsigned DdW    = 37;            // d*d magnitude, below 2^37
  localparam int unsigned DdLoW  = 19;            // low slice of d*d per pass
  localparam int unsigned MulAW  = 21;            // shared multiplier, operand A
  localparam int unsigned MulBW  = 20;            // shared multiplier, operand B
  localparam int unsigned MulPW  = MulAW + MulBW; // 41-bit product
  localparam int unsigned AccW   = 60;            // full quadratic term fits
  localparam int unsigned QuadSh = 31;
  localparam int unsigned LinSh  = 16;
  localparam int unsigned CntW   = 8;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;

  localparam logic [17:0]        JumpLimitRst = 18'd3840;
  localparam logic [CntW-1:0]    ErrResetRst  = 8'd15;
  localparam logic signed [20:0] CoefSqRst    = -21'sd5768;
  localparam logic signed [18:0] CoefLinRst   = 19'sd92370;
  localparam logic signed [15:0] CoefOfsRst   = 16'sd127;

  typedef enum logic [2:0] {
    REG_JUMP_LIMIT,
    REG_ERR_RESET,
    REG_COEF_SQ,
    REG_COEF_LIN,
    REG_COEF_OFS
  } reg_idx_e;

  typedef struct packed {
    logic [17:0]        jump_limit;
    logic [CntW-1:0]    error_reset_count;
    logic signed [20:0] coef_square;
    logic signed [18:0] coef_linear;
    logic signed [15:0] coef_offset;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_LO,
    ST_HI,
    ST_LIN,
    ST_SUM,
    ST_OFS,
    ST_FIN
  } state_e;

  typedef enum logic [1:0] {
    MUL_DD,
    MUL_LO,
    MUL_HI,
    MUL_LIN
  } mul_sel_e;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD_HI,
    ACC_ADD_LIN,
    ACC_ADD_OFS
  } acc_op_e;

  typedef struct packed {
    logic     load;
    mul_sel_e mul_sel;
    logic     dd_en;
    logic     prod_en;
    acc_op_e  acc_op;
  } ctrl_t;

endpackage

### sv/tgfc_if.sv
// Interfaces: reading channel and result channel, valid/ready handshake.
`timescale 1ns / 1ps
interface tgfc_item_if;
  logic                                valid;
  logic                                ready;
  logic signed [tgfc_pkg::TcW-1:0]     tc_temp;
  logic signed [tgfc_pkg::CjW-1:0]     cj_temp;
  logic [7:0]                          fault_bits;
  logic                                reading_invalid;
  logic                                firing_mode;

  modport source (output valid, tc_temp, cj_temp, fault_bits, reading_invalid,
                  firing_mode, input ready);
  modport sink (input valid, tc_temp, cj_temp, fault_bits, reading_invalid,
                firing_mode, output ready);
endinterface

interface tgfc_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [tgfc_pkg::TempW-1:0]   temperature;
  logic                                accepted;
  logic [tgfc_pkg::CntW-1:0]           error_count;
  logic                                has_error;
  logic                                reset_sensor;

  modport source (output valid, temperature, accepted, error_count, has_error,
                  reset_sensor, input ready);
  modport sink (input valid, temperature, accepted, error_count, has_error,
                reset_sensor, output ready);
endinterface

### sv/tgfc_cfg.sv
// APB register file: jump limit, reset count and calibration coefficients.
`timescale 1ns / 1ps
module tgfc_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tgfc_pkg::AddrW-1:0]    paddr,
  input  logic [tgfc_pkg::DataW-1:0]    pwdata,
  output logic [tgfc_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  output tgfc_pkg::cfg_t                cfg_o
);

  tgfc_pkg::cfg_t     cfg_q, cfg_d;
  tgfc_pkg::reg_idx_e idx;
  logic               wr_en;

  assign idx    = tgfc_pkg::reg_idx_e'(paddr[tgfc_pkg::AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        tgfc_pkg::REG_JUMP_LIMIT: cfg_d.jump_limit        = pwdata[17:0];
        tgfc_pkg::REG_ERR_RESET:  cfg_d.error_reset_count = pwdata[tgfc_pkg::CntW-1:0];
        tgfc_pkg::REG_COEF_SQ:    cfg_d.coef_square       = pwdata[20:0];
        tgfc_pkg::REG_COEF_LIN:   cfg_d.coef_linear       = pwdata[18:0];
        tgfc_pkg::REG_COEF_OFS:   cfg_d.coef_offset       = pwdata[15:0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      tgfc_pkg::REG_JUMP_LIMIT: prdata = {14'd0, cfg_q.jump_limit};
      tgfc_pkg::REG_ERR_RESET:  prdata = {24'd0, cfg_q.error_reset_count};
      tgfc_pkg::REG_COEF_SQ:    prdata = {{11{cfg_q.coef_square[20]}}, cfg_q.coef_square};
      tgfc_pkg::REG_COEF_LIN:   prdata = {{13{cfg_q.coef_linear[18]}}, cfg_q.coef_linear};
      tgfc_pkg::REG_COEF_OFS:   prdata = {{16{cfg_q.coef_offset[15]}}, cfg_q.coef_offset};
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.jump_limit        <= tgfc_pkg::JumpLimitRst;
      cfg_q.error_reset_count <= tgfc_pkg::ErrResetRst;
      cfg_q.coef_square       <= tgfc_pkg::CoefSqRst;
      cfg_q.coef_linear       <= tgfc_pkg::CoefLinRst;
      cfg_q.coef_offset       <= tgfc_pkg::CoefOfsRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### sv/tgfc_mac.sv
// Calibration datapath: one shared 21x20 multiplier and a 60-bit accumulator.
`timescale 1ns / 1ps
module tgfc_mac (
  input  logic                                clk_i,
  input  tgfc_pkg::ctrl_t                     ctrl_i,
  input  tgfc_pkg::cfg_t                      cfg_i,
  input  logic signed [tgfc_pkg::TcW-1:0]     tc_temp_i,
  input  logic signed [tgfc_pkg::CjW-1:0]     cj_temp_i,
  output logic signed [tgfc_pkg::TempW-1:0]   sat_temp_o
);

  localparam int unsigned AccW  = tgfc_pkg::AccW;
  localparam int unsigned MulPW = tgfc_pkg::MulPW;
  localparam int unsigned DdW   = tgfc_pkg::DdW;
  localparam int unsigned DdLoW = tgfc_pkg::DdLoW;
  localparam logic signed [AccW-1:0] SatHi = AccW'((2 ** (tgfc_pkg::TempW - 1)) - 1);
  localparam logic signed [AccW-1:0] SatLo = -SatHi - AccW'(1);

  logic signed [tgfc_pkg::DiffW-1:0] d_q;
  logic signed [tgfc_pkg::CjW-1:0]   cj_q;
  logic [DdW-1:0]                    dd_q;
  logic signed [MulPW-1:0]           prod_q;
  logic signed [AccW-1:0]            acc_q, acc_d;

  logic signed [tgfc_pkg::MulAW-1:0] mul_a;
  logic signed [tgfc_pkg::MulBW-1:0] mul_b;
  logic signed [MulPW-1:0]           mul_p;
  logic signed [AccW-1:0]            prod_ext, ofs_ext, cj_ext;

  always_comb begin
    case (ctrl_i.mul_sel)
      tgfc_pkg::MUL_DD: begin
        mul_a = {d_q[tgfc_pkg::DiffW-1], d_q};
        mul_b = d_q;
      end
      tgfc_pkg::MUL_LO: begin
        mul_a = cfg_i.coef_square;
        mul_b = {1'b0, dd_q[DdLoW-1:0]};
      end
      tgfc_pkg::MUL_HI: begin
        mul_a = cfg_i.coef_square;
        mul_b = {2'b00, dd_q[DdW-1:DdLoW]};
      end
      default: begin
        mul_a = {{2{cfg_i.coef_linear[18]}}, cfg_i.coef_linear};
        mul_b = d_q;
      end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign prod_ext = {{(AccW-MulPW){prod_q[MulPW-1]}}, prod_q};
  assign ofs_ext  = {{(AccW-16){cfg_i.coef_offset[15]}}, cfg_i.coef_offset};
  assign cj_ext   = {{(AccW-tgfc_pkg::CjW){cj_q[tgfc_pkg::CjW-1]}}, cj_q};

  // floor shifts come for free from arithmetic right shifts
  always_comb begin
    case (ctrl_i.acc_op)
      tgfc_pkg::ACC_LOAD:    acc_d = prod_ext;
      tgfc_pkg::ACC_ADD_HI:  acc_d = acc_q + (prod_ext <<< DdLoW);
      tgfc_pkg::ACC_ADD_LIN: acc_d = (acc_q >>> tgfc_pkg::QuadSh)
                                     + (prod_ext >>> tgfc_pkg::LinSh);
      tgfc_pkg::ACC_ADD_OFS: acc_d = acc_q + ofs_ext + cj_ext;
      default:               acc_d = acc_q;
    endcase
  end

  always_comb begin
    if (acc_q > SatHi) begin
      sat_temp_o = SatHi[tgfc_pkg::TempW-1:0];
    end else if (acc_q < SatLo) begin
      sat_temp_o = SatLo[tgfc_pkg::TempW-1:0];
    end else begin
      sat_temp_o = acc_q[tgfc_pkg::TempW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      d_q  <= {tc_temp_i[tgfc_pkg::TcW-1], tc_temp_i}
              - {{(tgfc_pkg::DiffW-tgfc_pkg::CjW){cj_temp_i[tgfc_pkg::CjW-1]}}, cj_temp_i};
      cj_q <= cj_temp_i;
    end
    if (ctrl_i.dd_en) begin
      dd_q <= mul_p[DdW-1:0];
    end
    if (ctrl_i.prod_en) begin
      prod_q <= mul_p;
    end
    acc_q <= acc_d;
  end

endmodule

### sv/tgfc_seq.sv
// Sequencer: acceptance test, held value, reject counter and result register.
`timescale 1ns / 1ps
module tgfc_seq (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  tgfc_item_if.sink                           item_i,
  tgfc_result_if.source                       result_o,
  input  tgfc_pkg::cfg_t                      cfg_i,
  input  logic signed [tgfc_pkg::TempW-1:0]   sat_temp_i,
  output tgfc_pkg::ctrl_t                     ctrl_o
);

  localparam int unsigned CntW = tgfc_pkg::CntW;
  localparam int unsigned DW   = tgfc_pkg::DiffW;

  tgfc_pkg::state_e state_q, state_d;

  logic signed [tgfc_pkg::TempW-1:0] held_q, held_d;
  logic [CntW-1:0]                   count_q, count_d;
  logic                              acc_q, firing_q;

  logic                              out_valid_q, out_valid_d;
  logic signed [tgfc_pkg::TempW-1:0] out_temp_q;
  logic                              out_acc_q, out_pulse_q, pulse_d;
  logic [CntW-1:0]                   out_count_q;

  logic                              take, fin_fire, accept_now;
  logic signed [DW-1:0]              jump;
  logic [DW-1:0]                     jump_abs;

  assign take = item_i.valid && item_i.ready;

  // jump from held value, decided as the reading arrives
  assign jump     = {held_q[tgfc_pkg::TempW-1], held_q}
                    - {item_i.tc_temp[tgfc_pkg::TcW-1], item_i.tc_temp};
  assign jump_abs = jump[DW-1] ? DW'(-jump) : DW'(jump);
  assign accept_now = (item_i.fault_bits == 8'd0) && !item_i.reading_invalid
                      && ((held_q == '0) || (jump_abs < {2'b00, cfg_i.jump_limit}));

  assign fin_fire = (state_q == tgfc_pkg::ST_FIN) && (!out_valid_q || result_o.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tgfc_pkg::ST_IDLE: begin
        if (item_i.valid) begin
          state_d = accept_now ? tgfc_pkg::ST_SQ : tgfc_pkg::ST_FIN;
        end
      end
      tgfc_pkg::ST_SQ:  state_d = tgfc_pkg::ST_LO;
      tgfc_pkg::ST_LO:  state_d = tgfc_pkg::ST_HI;
      tgfc_pkg::ST_HI:  state_d = tgfc_pkg::ST_LIN;
      tgfc_pkg::ST_LIN: state_d = tgfc_pkg::ST_SUM;
      tgfc_pkg::ST_SUM: state_d = tgfc_pkg::ST_OFS;
      tgfc_pkg::ST_OFS: state_d = tgfc_pkg::ST_FIN;
      tgfc_pkg::ST_FIN: begin
        if (fin_fire) begin
          state_d = tgfc_pkg::ST_IDLE;
        end
      end
      default: state_d = tgfc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    item_i.ready   = 1'b0;
    ctrl_o.load    = 1'b0;
    ctrl_o.mul_sel = tgfc_pkg::MUL_DD;
    ctrl_o.dd_en   = 1'b0;
    ctrl_o.prod_en = 1'b0;
    ctrl_o.acc_op  = tgfc_pkg::ACC_HOLD;
    unique case (state_q)
      tgfc_pkg::ST_IDLE: begin
        item_i.ready = 1'b1;
        ctrl_o.load  = item_i.valid;
      end
      tgfc_pkg::ST_SQ: begin
        ctrl_o.mul_sel = tgfc_pkg::MUL_DD;
        ctrl_o.dd_en   = 1'b1;
      end
      tgfc_pkg::ST_LO: begin
        ctrl_o.mul_sel = tgfc_pkg::MUL_LO;
        ctrl_o.prod_en = 1'b1;
      end
      tgfc_pkg::ST_HI: begin
        ctrl_o.mul_sel = tgfc_pkg::MUL_HI;
        ctrl_o.prod_en = 1'b1;
        ctrl_o.acc_op  = tgfc_pkg::ACC_LOAD;
      end
      tgfc_pkg::ST_LIN: begin
        ctrl_o.mul_sel = tgfc_pkg::MUL_LIN;
        ctrl_o.prod_en = 1'b1;
        ctrl_o.acc_op  = tgfc_pkg::ACC_ADD_HI;
      end
      tgfc_pkg::ST_SUM: ctrl_o.acc_op = tgfc_pkg::ACC_ADD_LIN;
      tgfc_pkg::ST_OFS: ctrl_o.acc_op = tgfc_pkg::ACC_ADD_OFS;
      tgfc_pkg::ST_FIN: ctrl_o.acc_op = tgfc_pkg::ACC_HOLD;
      default:          ctrl_o.acc_op = tgfc_pkg::ACC_HOLD;
    endcase
  end

  // filter state update at the end of each reading
  always_comb begin
    held_d  = held_q;
    count_d = count_q;
    pulse_d = 1'b0;
    if (acc_q) begin
      held_d  = sat_temp_i;
      count_d = '0;
    end else if (firing_q && (count_q != {CntW{1'b1}})) begin
      count_d = count_q + CntW'(1);
      pulse_d = (count_d == cfg_i.error_reset_count);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fin_fire) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tgfc_pkg::ST_IDLE;
      held_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (fin_fire) begin
        held_q  <= held_d;
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      acc_q    <= accept_now;
      firing_q <= item_i.firing_mode;
    end
    if (fin_fire) begin
      out_temp_q  <= held_d;
      out_acc_q   <= acc_q;
      out_count_q <= count_d;
      out_pulse_q <= pulse_d;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.temperature  = out_temp_q;
  assign result_o.accepted     = out_acc_q;
  assign result_o.error_count  = out_count_q;
  assign result_o.has_error    = (out_count_q != '0);
  assign result_o.reset_sensor = out_pulse_q;

endmodule

### sv/thermocouple_glitch_filter_calibrate.sv
// Top level: thermocouple glitch filter with quadratic calibration.
`timescale 1ns / 1ps
// Takes one thermocouple transaction (reading, cold-junction temperature,
// fault byte, invalid and firing flags) and returns exactly one result
// transaction. A reading is applied when the fault byte is zero, it is
// valid, and either the held value is zero or its distance from the held
// value is strictly below jump_limit. An applied reading is calibrated as
// c2*d*d/2^31 + c1*d/2^16 + c0 + cj with d = tc - cj (both shifts round
// towards minus infinity), saturated to 19 bits, and clears the reject
// count; a rejected one keeps the held value and, in firing mode only,
// bumps the saturating count, pulsing reset_sensor when the count lands on
// error_reset_count. Timing: the block takes one transaction at a time.
// A rejected reading goes from idle straight to the final state, where
// its result is registered; an applied one first runs the four passes
// of the single 21x20 multiplier (d*d, two halves of c2*d*d, c1*d)
// feeding one accumulator, plus the offset add and saturation. The next
// reading is taken the cycle after the result is registered, even if
// that result is still waiting on the output. The result register is
// only reloaded once it is free or being taken, so a stalled output
// holds the block in its final state.
// Results are held in an output register until taken.
// Registers sit on an APB port at byte addresses 0x00..0x10, one word each:
// jump_limit, error_reset_count, coef_square, coef_linear, coef_offset.
// Write only while the block is idle.
module thermocouple_glitch_filter_calibrate (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tgfc_item_if.sink                     item_i,
  tgfc_result_if.source                 result_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tgfc_pkg::AddrW-1:0]    paddr,
  input  logic [tgfc_pkg::DataW-1:0]    pwdata,
  output logic [tgfc_pkg::DataW-1:0]    prdata,
  output logic                          pready
);

  tgfc_pkg::cfg_t                    cfg;
  tgfc_pkg::ctrl_t                   ctrl;
  logic signed [tgfc_pkg::TempW-1:0] sat_temp;

  // register file
  tgfc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // shared multiplier and accumulator
  tgfc_mac u_mac (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .cfg_i      (cfg),
    .tc_temp_i  (item_i.tc_temp),
    .cj_temp_i  (item_i.cj_temp),
    .sat_temp_o (sat_temp)
  );

  // sequencer, filter state and result register
  tgfc_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_i),
    .result_o   (result_o),
    .cfg_i      (cfg),
    .sat_temp_i (sat_temp),
    .ctrl_o     (ctrl)
  );

  // a reset pulse only ever reports the count that triggered it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.reset_sensor) |->
      (result_o.error_count == cfg.error_reset_count) && result_o.has_error)
    else $error("reset pulse without matching error count");

  // an applied reading always clears the reject count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.accepted) |->
      (result_o.error_count == '0) && !result_o.has_error)
    else $error("applied reading left a nonzero error count");

  // once a transaction is taken the block is busy in the cycle after it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.valid && item_i.ready) |=> !item_i.ready)
    else $error("second transaction taken back to back");

  // the datapath is only loaded on a taken transaction, applied or rejected
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.load |-> item_i.ready)
    else $error("datapath loaded while busy");

endmodule
